>>> design/dcrpa_pkg.sv
// ----------------------------------------------------------------------------
// dcrpa_pkg
// Shared types and constants for the data-cache request port arbiter.
// ----------------------------------------------------------------------------
package dcrpa_pkg;

	localparam int QUEUE_DEPTH  = 64;
	localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int LOCK_ENTRIES = 4;
	localparam int MAX_PORTS    = 8;
	localparam int MAX_RESULTS  = 8;
	localparam int RIDX_W       = $clog2(MAX_RESULTS);
	localparam int RCNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int ADDR_W       = 48;
	localparam int TAG_W        = 8;

	// request functions
	localparam logic [1:0] FN_REQ   = 2'd0;
	localparam logic [1:0] FN_RETRY = 2'd1;
	localparam logic [1:0] FN_TICK  = 2'd2;
	localparam logic [1:0] FN_NONE  = 2'd3;

	// configuration register indexes
	localparam logic CFG_NUM_PORTS = 1'b0;
	localparam logic CFG_LINE_OFS  = 1'b1;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic              core;
		logic              rmw;
		logic              wr;
		logic [ADDR_W-1:0] addr;
	} qent_t;

	// shift control broadcast along the queue chain
	typedef struct packed {
		logic              ins;
		logic              pop;
		logic [QIDX_W-1:0] pos;
	} qctl_t;

	typedef struct packed {
		logic lock;
		logic unlock;
	} lkop_t;

	typedef struct packed {
		logic hit;
		logic full;
	} lkstat_t;

	// clear the offset bits below the line size
	function automatic logic [ADDR_W-1:0] line_of(input logic [ADDR_W-1:0] addr,
			input logic [3:0] lob);
		return addr & ~((ADDR_W'(1) << lob) - ADDR_W'(1));
	endfunction

endpackage

>>> design/dcrpa_qcell.sv
// ----------------------------------------------------------------------------
// dcrpa_qcell
// One slot of the pending queue; shifts toward the tail on insert and toward
// the head on a send.
// ----------------------------------------------------------------------------
module dcrpa_qcell (
	input  logic                       clk,
	input  logic [dcrpa_pkg::QIDX_W-1:0] idx,
	input  dcrpa_pkg::qctl_t           ctl,
	input  dcrpa_pkg::qent_t           new_ent,
	input  dcrpa_pkg::qent_t           prev_ent,
	input  dcrpa_pkg::qent_t           next_ent,
	output dcrpa_pkg::qent_t           ent
);

	dcrpa_pkg::qent_t ent_q;

	// load new entry, open a gap, or advance toward the head
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx == ctl.pos)
				ent_q <= new_ent;
			else if (idx > ctl.pos)
				ent_q <= prev_ent;
		end else if (ctl.pop) begin
			ent_q <= next_ent;
		end
	end

	assign ent = ent_q;

endmodule

>>> design/dcrpa_lock.sv
// ----------------------------------------------------------------------------
// dcrpa_lock
// RMW line lock table: lookup of one line, lock into the first free entry,
// unlock of the matching entry.
// ----------------------------------------------------------------------------
module dcrpa_lock (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [3:0]                   lob,
	input  logic [dcrpa_pkg::ADDR_W-1:0] qaddr,
	input  dcrpa_pkg::lkop_t             op,
	output dcrpa_pkg::lkstat_t           stat
);

	logic [dcrpa_pkg::LOCK_ENTRIES-1:0] vld_q;
	logic [dcrpa_pkg::ADDR_W-1:0]       line_q [dcrpa_pkg::LOCK_ENTRIES];
	logic [dcrpa_pkg::ADDR_W-1:0]       qline;
	logic [dcrpa_pkg::LOCK_ENTRIES-1:0] hit_v;
	logic [dcrpa_pkg::LOCK_ENTRIES-1:0] free_v;

	assign qline = dcrpa_pkg::line_of(qaddr, lob);

	// match and first-free search
	always_comb begin
		logic found;
		found = 1'b0;
		for (int i = 0; i < dcrpa_pkg::LOCK_ENTRIES; i++) begin
			hit_v[i]  = vld_q[i] && (line_q[i] == qline);
			free_v[i] = !vld_q[i] && !found;
			if (!vld_q[i])
				found = 1'b1;
		end
	end

	assign stat.hit  = |hit_v;
	assign stat.full = ~|free_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (op.lock && !stat.hit) begin
			vld_q <= vld_q | free_v;
		end else if (op.unlock) begin
			vld_q <= vld_q & ~hit_v;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < dcrpa_pkg::LOCK_ENTRIES; i++)
			if (op.lock && !stat.hit && free_v[i])
				line_q[i] <= qline;
	end

endmodule

>>> design/dcache_request_port_arbiter.sv
// ----------------------------------------------------------------------------
// dcache_request_port_arbiter
// Data-cache request port with a pending queue, per-cycle port budget and
// RMW line locking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one step beat: a new request, a
//   downstream retry, a drain tick or a no-op. Output channel (out_valid/
//   out_stall) returns one beat per request sent, or one status beat if none
//   was sent; the final beat of a step carries last.
//   A step is accepted; the drain then sends queue entries from the head cell
//   of the queue chain, one send per cycle and at most 8 per step; the result
//   beats follow. One step is in flight at a time; in_stall is high until its
//   last beat is loaded into the output register. The pending queue is a chain
//   of 64 cells; an insert shifts the cells from its position toward the tail,
//   a send shifts all cells toward the head. A stalled receiver holds the
//   output register and the step. Reset (arst_n low) empties the queue, clears
//   all line locks, the blocked flag and the port count, and sets num_ports to
//   2, line_offset_bits to 6. The user must write configuration through
//   cfg_we/cfg_index/cfg_data only while idle; the block leaves this to them.
// ----------------------------------------------------------------------------
module dcache_request_port_arbiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [3:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic                          new_cycle,
	input  logic [dcrpa_pkg::TAG_W-1:0]   request_tag,
	input  logic                          from_core,
	input  logic                          stream_control,
	input  logic                          locked_rmw,
	input  logic                          write_access,
	input  logic [dcrpa_pkg::ADDR_W-1:0]  phys_addr,
	input  logic [3:0]                    downstream_accepts,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          sent_valid,
	output logic [dcrpa_pkg::TAG_W-1:0]   sent_tag,
	output logic                          sent_bypass,
	output logic                          last,
	output logic                          port_blocked,
	output logic [6:0]                    queue_count,
	output logic                          lock_error,
	output logic                          overflow_error
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DRAIN = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t                           state_q, state_d;
	logic [3:0]                       np_q, lob_q;
	logic [dcrpa_pkg::CNT_W-1:0]      cnt_q, cnt_d, core_cnt_q, core_cnt_d;
	logic [3:0]                       used_q, used_d;
	logic                             blk_q, blk_d;
	logic [3:0]                       budget_q, budget_d, acc_q, acc_d;
	logic                             elock_q, elock_d, eover_q, eover_d;
	logic [dcrpa_pkg::RCNT_W-1:0]     nsent_q, nsent_d, k_q, k_d;
	logic [dcrpa_pkg::TAG_W-1:0]      rtag_q [dcrpa_pkg::MAX_RESULTS];
	logic                             rbyp_q [dcrpa_pkg::MAX_RESULTS];
	logic                             rwr_en, rwr_byp;
	logic [dcrpa_pkg::TAG_W-1:0]      rwr_tag;
	logic [dcrpa_pkg::RIDX_W-1:0]     rwr_idx;
	logic                             ov_q, oload;
	logic                             o_sv_d, o_byp_d, o_last_d;
	logic [dcrpa_pkg::TAG_W-1:0]      o_tag_d;
	logic                             o_sv_q, o_byp_q, o_last_q, o_blk_q, o_el_q, o_eo_q;
	logic [dcrpa_pkg::TAG_W-1:0]      o_tag_q;
	logic [6:0]                       o_cnt_q;

	dcrpa_pkg::qctl_t                 qctl;
	dcrpa_pkg::qent_t                 new_ent;
	dcrpa_pkg::qent_t                 q_ent [dcrpa_pkg::QUEUE_DEPTH];
	dcrpa_pkg::qent_t                 head;
	dcrpa_pkg::lkop_t                 lkop;
	dcrpa_pkg::lkstat_t               lkst;
	logic [dcrpa_pkg::ADDR_W-1:0]     lk_addr;
	logic [3:0]                       ports;
	logic [dcrpa_pkg::RCNT_W-1:0]     nres;
	logic                             accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign head     = q_ent[0];
	assign ports    = (np_q > 4'(dcrpa_pkg::MAX_PORTS)) ? 4'(dcrpa_pkg::MAX_PORTS) : np_q;
	assign lk_addr  = (state_q == ST_DRAIN) ? head.addr : phys_addr;
	assign nres     = (nsent_q == '0) ? dcrpa_pkg::RCNT_W'(1) : nsent_q;
	assign oload    = !ov_q || !out_stall;
	// a bypass beat is the first of its step
	assign rwr_idx  = (state_q == ST_DRAIN) ? nsent_q[dcrpa_pkg::RIDX_W-1:0] : '0;

	assign new_ent.tag  = request_tag;
	assign new_ent.core = from_core;
	assign new_ent.rmw  = locked_rmw;
	assign new_ent.wr   = write_access;
	assign new_ent.addr = phys_addr;

	// queue chain
	for (genvar i = 0; i < dcrpa_pkg::QUEUE_DEPTH; i++) begin : g_cell
		dcrpa_qcell u_cell (
			.clk      (clk),
			.idx      (dcrpa_pkg::QIDX_W'(i)),
			.ctl      (qctl),
			.new_ent  (new_ent),
			.prev_ent ((i == 0) ? new_ent : q_ent[(i == 0) ? 0 : i - 1]),
			.next_ent (q_ent[(i == dcrpa_pkg::QUEUE_DEPTH - 1) ? i : i + 1]),
			.ent      (q_ent[i])
		);
	end

	dcrpa_lock u_lock (
		.clk    (clk),
		.arst_n (arst_n),
		.lob    (lob_q),
		.qaddr  (lk_addr),
		.op     (lkop),
		.stat   (lkst)
	);

	// step sequencer
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		core_cnt_d = core_cnt_q;
		used_d     = used_q;
		blk_d      = blk_q;
		budget_d   = budget_q;
		acc_d      = acc_q;
		elock_d    = elock_q;
		eover_d    = eover_q;
		nsent_d    = nsent_q;
		k_d        = k_q;
		qctl.ins   = 1'b0;
		qctl.pop   = 1'b0;
		qctl.pos   = core_cnt_q[dcrpa_pkg::QIDX_W-1:0];
		lkop       = '0;
		rwr_en     = 1'b0;
		rwr_tag    = head.tag;
		rwr_byp    = 1'b0;
		o_sv_d     = 1'b0;
		o_tag_d    = '0;
		o_byp_d    = 1'b0;
		o_last_d   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (new_cycle)
						used_d = '0;
					budget_d = downstream_accepts;
					acc_d    = '0;
					elock_d  = 1'b0;
					eover_d  = 1'b0;
					nsent_d  = '0;
					k_d      = '0;
					state_d  = ST_EMIT;
					case (func)
						dcrpa_pkg::FN_REQ: begin
							if (!from_core && stream_control) begin
								rwr_en  = 1'b1;
								rwr_tag = request_tag;
								rwr_byp = 1'b1;
								nsent_d = dcrpa_pkg::RCNT_W'(1);
							end else begin
								if (cnt_q == dcrpa_pkg::CNT_W'(dcrpa_pkg::QUEUE_DEPTH)) begin
									eover_d = 1'b1;
								end else begin
									qctl.ins = 1'b1;
									qctl.pos = from_core ? core_cnt_q[dcrpa_pkg::QIDX_W-1:0]
										: cnt_q[dcrpa_pkg::QIDX_W-1:0];
									cnt_d = cnt_q + 1'b1;
									if (from_core)
										core_cnt_d = core_cnt_q + 1'b1;
								end
								if (locked_rmw && write_access && (!from_core || !lkst.hit))
									elock_d = 1'b1;
								if (!blk_q)
									state_d = ST_DRAIN;
							end
						end
						dcrpa_pkg::FN_RETRY: begin
							blk_d   = 1'b0;
							state_d = ST_DRAIN;
						end
						dcrpa_pkg::FN_TICK: begin
							if (!blk_q)
								state_d = ST_DRAIN;
						end
						default: ;
					endcase
				end
			end
			ST_DRAIN: begin
				if (cnt_q == '0 || blk_q || used_q >= ports ||
						nsent_q >= dcrpa_pkg::RCNT_W'(dcrpa_pkg::MAX_RESULTS)) begin
					state_d = ST_EMIT;
				end else if (lkst.hit && !(head.rmw && head.wr)) begin
					state_d = ST_EMIT;
				end else if (acc_q >= budget_q) begin
					blk_d   = 1'b1;
					state_d = ST_EMIT;
				end else begin
					// send the head beat
					acc_d    = acc_q + 1'b1;
					used_d   = used_q + 1'b1;
					rwr_en   = 1'b1;
					nsent_d  = nsent_q + 1'b1;
					qctl.pop = 1'b1;
					cnt_d    = cnt_q - 1'b1;
					if (head.core)
						core_cnt_d = core_cnt_q - 1'b1;
					if (head.rmw) begin
						if (!head.wr) begin
							if (lkst.hit)
								elock_d = 1'b1;
							else if (lkst.full)
								eover_d = 1'b1;
							else
								lkop.lock = 1'b1;
						end else begin
							if (lkst.hit)
								lkop.unlock = 1'b1;
							else
								elock_d = 1'b1;
						end
					end
				end
			end
			ST_EMIT: begin
				o_sv_d   = (nsent_q != '0);
				o_tag_d  = o_sv_d ? rtag_q[k_q[dcrpa_pkg::RIDX_W-1:0]] : '0;
				o_byp_d  = o_sv_d && rbyp_q[k_q[dcrpa_pkg::RIDX_W-1:0]];
				o_last_d = (k_q + 1'b1 == nres);
				if (oload) begin
					k_d = k_q + 1'b1;
					if (o_last_d)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			np_q       <= 4'd2;
			lob_q      <= 4'd6;
			cnt_q      <= '0;
			core_cnt_q <= '0;
			used_q     <= '0;
			blk_q      <= 1'b0;
			budget_q   <= '0;
			acc_q      <= '0;
			elock_q    <= 1'b0;
			eover_q    <= 1'b0;
			nsent_q    <= '0;
			k_q        <= '0;
			ov_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			core_cnt_q <= core_cnt_d;
			used_q     <= used_d;
			blk_q      <= blk_d;
			budget_q   <= budget_d;
			acc_q      <= acc_d;
			elock_q    <= elock_d;
			eover_q    <= eover_d;
			nsent_q    <= nsent_d;
			k_q        <= k_d;
			if (cfg_we) begin
				if (cfg_index == dcrpa_pkg::CFG_NUM_PORTS)
					np_q <= cfg_data;
				else
					lob_q <= cfg_data;
			end
			if (state_q == ST_EMIT && oload)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	// result buffer
	always_ff @(posedge clk) begin
		if (rwr_en) begin
			rtag_q[rwr_idx] <= rwr_tag;
			rbyp_q[rwr_idx] <= rwr_byp;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && oload) begin
			o_sv_q   <= o_sv_d;
			o_tag_q  <= o_tag_d;
			o_byp_q  <= o_byp_d;
			o_last_q <= o_last_d;
			o_blk_q  <= blk_q;
			o_cnt_q  <= 7'(cnt_q);
			o_el_q   <= elock_q;
			o_eo_q   <= eover_q;
		end
	end

	assign out_valid      = ov_q;
	assign sent_valid     = o_sv_q;
	assign sent_tag       = o_tag_q;
	assign sent_bypass    = o_byp_q;
	assign last           = o_last_q;
	assign port_blocked   = o_blk_q;
	assign queue_count    = o_cnt_q;
	assign lock_error     = o_el_q;
	assign overflow_error = o_eo_q;

	a_core_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		core_cnt_q <= cnt_q) else $error("core count exceeds queue count");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dcrpa_pkg::CNT_W'(dcrpa_pkg::QUEUE_DEPTH)) else $error("queue overrun");
	a_sends: assert property (@(posedge clk) disable iff (!arst_n)
		nsent_q <= dcrpa_pkg::RCNT_W'(dcrpa_pkg::MAX_RESULTS)) else $error("too many sends");
	a_ports: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= 4'(dcrpa_pkg::MAX_PORTS)) else $error("port count overrun");

endmodule
